// ===== sv/pvd_pkg.sv =====
// ----------------------------------------------------------------------------
// pvd_pkg
// shared types, widths and helpers for the polynomial value and slope block
// ----------------------------------------------------------------------------
package pvd_pkg;

  localparam int MAX_TERMS_DEF = 6;

  localparam int COEF_W   = 64;
  localparam int POINT_W  = 32;
  localparam int INDEX_W  = 3;
  localparam int COUNT_W  = 3;
  localparam int FRAC_SHIFT = 20;

  // input tdata layout
  localparam int IN_IDX_LSB   = 0;
  localparam int IN_COEF_LSB  = IN_IDX_LSB + INDEX_W;
  localparam int IN_POINT_LSB = IN_COEF_LSB + COEF_W;
  localparam int IN_CNT_LSB   = IN_POINT_LSB + POINT_W;
  localparam int IN_BITS      = IN_CNT_LSB + COUNT_W;
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = 2 * COEF_W;

  // datapath widths
  localparam int HALF_W = COEF_W / 2;
  localparam int PROD_W = HALF_W + 1 + POINT_W;
  localparam int ACC_W  = COEF_W + POINT_W;
  localparam int TERM_W = COEF_W + 6;
  localparam int SUM_W  = ACC_W - FRAC_SHIFT + 1;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_SINIT,
    S_LO,
    S_HI,
    S_ADD,
    S_DONE
  } state_e;

  typedef struct packed {
    logic lo;
    logic hi;
  } mac_ctl_t;

  typedef struct packed {
    logic              ovf;
    logic [COEF_W-1:0] val;
  } sat_t;

  function automatic sat_t sat64(input logic signed [SUM_W-1:0] s);
    sat_t r;
    r.val = s[COEF_W-1:0];
    r.ovf = (s[SUM_W-1:COEF_W-1] != '0) && (s[SUM_W-1:COEF_W-1] != '1);
    if (r.ovf) begin
      r.val = s[SUM_W-1] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== sv/pvd_coef_store.sv =====
// ----------------------------------------------------------------------------
// pvd_coef_store
// coefficient memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module pvd_coef_store #(
  parameter int Depth = pvd_pkg::MAX_TERMS_DEF,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [AddrW-1:0]           wr_addr_i,
  input  logic [pvd_pkg::COEF_W-1:0] wr_data_i,
  input  logic                       rd_en_i,
  input  logic [AddrW-1:0]           rd_addr_i,
  output logic [pvd_pkg::COEF_W-1:0] rd_data_o
);

  logic [pvd_pkg::COEF_W-1:0] mem [Depth];
  logic [pvd_pkg::COEF_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/pvd_mac.sv =====
// ----------------------------------------------------------------------------
// pvd_mac
// shared multiply-accumulate: y*x in two half products, shift, add, saturate
// ----------------------------------------------------------------------------
module pvd_mac (
  input  logic                              clk_i,
  input  pvd_pkg::mac_ctl_t                 ctl_i,
  input  logic [pvd_pkg::COEF_W-1:0]        y_i,
  input  logic signed [pvd_pkg::POINT_W-1:0] x_i,
  input  logic signed [pvd_pkg::TERM_W-1:0] term_i,
  output pvd_pkg::sat_t                     res_o
);

  logic signed [pvd_pkg::HALF_W:0]     a_op;
  logic signed [pvd_pkg::PROD_W-1:0]   prod;
  logic signed [pvd_pkg::ACC_W-1:0]    acc_q, acc_d, shifted;
  logic signed [pvd_pkg::SUM_W-1:0]    sum;

  always_comb begin
    if (ctl_i.lo) begin
      a_op = signed'({1'b0, y_i[pvd_pkg::HALF_W-1:0]});
    end else begin
      a_op = signed'({y_i[pvd_pkg::COEF_W-1], y_i[pvd_pkg::COEF_W-1:pvd_pkg::HALF_W]});
    end
    prod = a_op * x_i;
  end

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.lo) begin
      acc_d = pvd_pkg::ACC_W'(prod);
    end else if (ctl_i.hi) begin
      acc_d = acc_q + (pvd_pkg::ACC_W'(prod) <<< pvd_pkg::HALF_W);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  always_comb begin
    shifted = acc_q >>> pvd_pkg::FRAC_SHIFT;
    sum     = signed'(shifted[pvd_pkg::SUM_W-1:0]) + pvd_pkg::SUM_W'(term_i);
    res_o   = pvd_pkg::sat64(sum);
  end

endmodule

// ===== sv/poly_value_and_derivative.sv =====
// ----------------------------------------------------------------------------
// poly_value_and_derivative
// Horner evaluation of a polynomial and its first derivative in fixed point
// ----------------------------------------------------------------------------
// Input beats on s_axis: tuser selects load (0) or evaluate (1). A load beat
// writes coef_value into entry coef_index of the coefficient memory and gives
// no output beat; an index at or beyond MAX_TERMS is dropped. An evaluate beat
// gives point x (Q11.20) and term_count n, clamped to MAX_TERMS, and yields
// one output beat on m_axis with p(x) and p'(x) in Q15.48 and an overflow
// flag in tuser when either chain saturated.
// Each Horner step runs on one shared 33x32 multiplier in two half products
// (S_LO, S_HI) followed by a shift, add and saturate step (S_ADD). While an
// evaluate beat is worked on, s_axis_tready stays low. A load beat leaves the
// sequencer idle, so the block stays ready for the next beat.
// The result sits in an output register, so the next beat is taken while the
// receiver stalls; a later result then waits until the register frees.
// Reset clears the sequencer and the output valid; the coefficient memory
// keeps whatever it held and must be loaded before use.
// ----------------------------------------------------------------------------
module poly_value_and_derivative #(
  parameter int MaxTerms = pvd_pkg::MAX_TERMS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // coef_index, coef_value, point, term_count, zero pad
  input  logic [pvd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // opcode
  input  logic [0:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // value, slope
  output logic [pvd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // overflow
  output logic [0:0]                      m_axis_tuser
);

  localparam int IdxW = $clog2(MaxTerms);
  localparam int CntW = $clog2(MaxTerms + 1);

  pvd_pkg::state_e state_q, state_d;

  logic [pvd_pkg::INDEX_W-1:0] in_idx;
  logic [pvd_pkg::COEF_W-1:0]  in_coef;
  logic [pvd_pkg::POINT_W-1:0] in_point;
  logic [pvd_pkg::COUNT_W-1:0] in_cnt;
  logic                        in_acc;
  logic [CntW-1:0]             n_clamp;

  logic [CntW-1:0]                   n_q, n_d;
  logic [IdxW-1:0]                   idx_q, idx_d;
  logic                              chain_q, chain_d;
  logic                              ov_q, ov_d;
  logic [pvd_pkg::COEF_W-1:0]        val_q, val_d, slope_q, slope_d;
  logic signed [pvd_pkg::POINT_W-1:0] x_q, x_d;
  logic signed [pvd_pkg::TERM_W-1:0] term_q, term_d;

  logic                        rd_en;
  logic [IdxW-1:0]             rd_addr;
  logic [pvd_pkg::COEF_W-1:0]  rd_data;
  logic                        wr_en;

  logic [CntW-1:0]                   k_sel;
  logic signed [pvd_pkg::TERM_W-1:0] c_ext, k_ext;
  pvd_pkg::mac_ctl_t                 mac_ctl;
  pvd_pkg::sat_t                     mac_res, init_res;

  logic                            out_valid_q;
  logic [pvd_pkg::OUT_TDATA_W-1:0] out_data_q;
  logic                            out_ov_q;
  logic                            out_load;

  assign in_idx   = s_axis_tdata[pvd_pkg::IN_IDX_LSB +: pvd_pkg::INDEX_W];
  assign in_coef  = s_axis_tdata[pvd_pkg::IN_COEF_LSB +: pvd_pkg::COEF_W];
  assign in_point = s_axis_tdata[pvd_pkg::IN_POINT_LSB +: pvd_pkg::POINT_W];
  assign in_cnt   = s_axis_tdata[pvd_pkg::IN_CNT_LSB +: pvd_pkg::COUNT_W];

  assign s_axis_tready = (state_q == pvd_pkg::S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign wr_en = in_acc && (s_axis_tuser[0] == pvd_pkg::OP_LOAD) && (int'(in_idx) < MaxTerms);
  assign n_clamp = (int'(in_cnt) > MaxTerms) ? CntW'(MaxTerms) : CntW'(in_cnt);
  assign out_load = (state_q == pvd_pkg::S_DONE) && (!out_valid_q || m_axis_tready);

  pvd_coef_store #(
    .Depth (MaxTerms),
    .AddrW (IdxW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (IdxW'(in_idx)),
    .wr_data_i (in_coef),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // derivative term c[i]*i, or the plain coefficient for the value chain
  always_comb begin
    k_sel  = (state_q == pvd_pkg::S_HEAD) ? CntW'(n_q - 1'b1) : CntW'(idx_q);
    c_ext  = pvd_pkg::TERM_W'(signed'(rd_data));
    k_ext  = signed'(pvd_pkg::TERM_W'(k_sel));
    term_d = chain_q ? c_ext * k_ext : c_ext;
  end

  always_comb begin
    mac_ctl.lo = (state_q == pvd_pkg::S_LO);
    mac_ctl.hi = (state_q == pvd_pkg::S_HI);
  end

  pvd_mac u_mac (
    .clk_i  (clk_i),
    .ctl_i  (mac_ctl),
    .y_i    (chain_q ? slope_q : val_q),
    .x_i    (x_q),
    .term_i (term_q),
    .res_o  (mac_res)
  );

  assign init_res = pvd_pkg::sat64(pvd_pkg::SUM_W'(term_q));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pvd_pkg::S_IDLE: begin
        if (in_acc && (s_axis_tuser[0] == pvd_pkg::OP_EVAL)) begin
          state_d = (n_clamp == '0) ? pvd_pkg::S_DONE : pvd_pkg::S_HEAD;
        end
      end
      pvd_pkg::S_HEAD: begin
        if (chain_q) begin
          state_d = pvd_pkg::S_SINIT;
        end else if (n_q == CntW'(1)) begin
          state_d = pvd_pkg::S_DONE;
        end else begin
          state_d = pvd_pkg::S_LO;
        end
      end
      pvd_pkg::S_SINIT: begin
        state_d = (n_q == CntW'(2)) ? pvd_pkg::S_DONE : pvd_pkg::S_LO;
      end
      pvd_pkg::S_LO: state_d = pvd_pkg::S_HI;
      pvd_pkg::S_HI: state_d = pvd_pkg::S_ADD;
      pvd_pkg::S_ADD: begin
        if (!chain_q && idx_q == '0) begin
          state_d = pvd_pkg::S_HEAD;
        end else if (chain_q && idx_q == IdxW'(1)) begin
          state_d = pvd_pkg::S_DONE;
        end else begin
          state_d = pvd_pkg::S_LO;
        end
      end
      pvd_pkg::S_DONE: begin
        if (out_load) begin
          state_d = pvd_pkg::S_IDLE;
        end
      end
      default: state_d = pvd_pkg::S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    n_d     = n_q;
    idx_d   = idx_q;
    chain_d = chain_q;
    ov_d    = ov_q;
    val_d   = val_q;
    slope_d = slope_q;
    x_d     = x_q;
    rd_en   = 1'b0;
    rd_addr = IdxW'(n_q - 1'b1);
    unique case (state_q)
      pvd_pkg::S_IDLE: begin
        n_d     = n_clamp;
        x_d     = signed'(in_point);
        chain_d = 1'b0;
        ov_d    = 1'b0;
        val_d   = '0;
        slope_d = '0;
        rd_en   = in_acc;
        rd_addr = IdxW'(n_clamp - 1'b1);
      end
      pvd_pkg::S_HEAD: begin
        if (!chain_q) begin
          val_d   = rd_data;
          idx_d   = IdxW'(n_q - CntW'(2));
          rd_en   = 1'b1;
          rd_addr = IdxW'(n_q - CntW'(2));
        end
      end
      pvd_pkg::S_SINIT: begin
        slope_d = init_res.val;
        ov_d    = ov_q | init_res.ovf;
        idx_d   = IdxW'(n_q - CntW'(2));
        rd_en   = 1'b1;
        rd_addr = IdxW'(n_q - CntW'(2));
      end
      pvd_pkg::S_LO, pvd_pkg::S_HI: begin
      end
      pvd_pkg::S_ADD: begin
        ov_d = ov_q | mac_res.ovf;
        if (chain_q) begin
          slope_d = mac_res.val;
        end else begin
          val_d = mac_res.val;
        end
        if (!chain_q && idx_q == '0) begin
          chain_d = 1'b1;
          rd_en   = 1'b1;
          rd_addr = IdxW'(n_q - 1'b1);
        end else begin
          idx_d   = idx_q - 1'b1;
          rd_en   = 1'b1;
          rd_addr = idx_q - 1'b1;
        end
      end
      pvd_pkg::S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pvd_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    idx_q   <= idx_d;
    chain_q <= chain_d;
    ov_q    <= ov_d;
    val_q   <= val_d;
    slope_q <= slope_d;
    x_q     <= x_d;
    if (state_q == pvd_pkg::S_HEAD || state_q == pvd_pkg::S_LO) begin
      term_q <= term_d;
    end
    if (out_load) begin
      out_data_q <= {slope_q, val_q};
      out_ov_q   <= ov_q;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_ov_q;

endmodule

// ===== tb/poly_eval_checker.sv =====
// ----------------------------------------------------------------------------
// poly_eval_checker
// watches both streams of the polynomial block, keeps its own copy of the
// coefficient memory, works out p(x), p'(x) and the saturation flag for every
// evaluate beat and compares each output beat with the oldest owed result
// ----------------------------------------------------------------------------
module poly_eval_checker
  import pvd_pkg::*;
#(
  parameter int MaxTerms = MAX_TERMS_DEF
) (
  input  logic                   clk_i,
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,
  input  logic [0:0]             s_tuser_i,
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_tdata_i,
  input  logic [0:0]             m_tuser_i,
  output int                     fail_count_o,
  output int                     owed_count_o,
  output int                     load_beats_o,
  output int                     dropped_loads_o,
  output int                     eval_beats_o,
  output int                     results_seen_o,
  output int                     saturated_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [COEF_W-1:0] value;
    logic [COEF_W-1:0] slope;
    logic              ovf;
  } poly_result_t;

  logic [COEF_W-1:0] coef_mem [MaxTerms];
  poly_result_t      owed_results [$];
  logic              chain_ovf;

  initial begin
    fail_count_o     = 0;
    owed_count_o     = 0;
    load_beats_o     = 0;
    dropped_loads_o  = 0;
    eval_beats_o     = 0;
    results_seen_o   = 0;
    saturated_seen_o = 0;
  end

  function automatic logic signed [127:0] widen(input logic [COEF_W-1:0] c);
    return {{(128-COEF_W){c[COEF_W-1]}}, c};
  endfunction

  function automatic logic [COEF_W-1:0] clamp64(input logic signed [127:0] s);
    if (s[127:COEF_W-1] != '0 && s[127:COEF_W-1] != '1) begin
      chain_ovf = 1'b1;
      return s[127] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
    end
    return s[COEF_W-1:0];
  endfunction

  // product y*x exact, floor shift back to Q15.48, exact add, saturate
  function automatic logic [COEF_W-1:0] horner_step(input logic [COEF_W-1:0] y,
                                                    input logic [POINT_W-1:0] x,
                                                    input logic signed [127:0] term);
    logic signed [127:0] yw;
    logic signed [127:0] xw;
    logic signed [127:0] prod;
    yw   = widen(y);
    xw   = {{(128-POINT_W){x[POINT_W-1]}}, x};
    prod = yw * xw;
    prod = prod >>> FRAC_SHIFT;
    return clamp64(prod + term);
  endfunction

  function automatic poly_result_t predict_eval(input logic [POINT_W-1:0] x,
                                                input logic [COUNT_W-1:0] cnt);
    poly_result_t        r;
    int                  n;
    logic signed [127:0] iw;
    n         = (int'(cnt) > MaxTerms) ? MaxTerms : int'(cnt);
    chain_ovf = 1'b0;
    r.value   = '0;
    r.slope   = '0;
    if (n >= 1) begin
      r.value = coef_mem[n-1];
      for (int i = n - 2; i >= 0; i--) begin
        r.value = horner_step(r.value, x, widen(coef_mem[i]));
      end
    end
    if (n == 2) begin
      r.slope = coef_mem[1];
    end else if (n > 2) begin
      iw      = n - 1;
      r.slope = clamp64(widen(coef_mem[n-1]) * iw);
      for (int i = n - 2; i >= 1; i--) begin
        iw      = i;
        r.slope = horner_step(r.slope, x, widen(coef_mem[i]) * iw);
      end
    end
    r.ovf = chain_ovf;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [COEF_W-1:0] got,
                                 input logic [COEF_W-1:0] want);
    $display("[%0t] mismatch on %s at result %0d: got %h, expected %h",
             $realtime, what, results_seen_o, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i) begin
    poly_result_t want;
    op_e          op;
    logic [2:0]   idx;
    if (m_tvalid_i && m_tready_i) begin
      if (owed_results.size() == 0) begin
        report_mismatch("unexpected beat", m_tdata_i[COEF_W-1:0], '0);
      end else begin
        want = owed_results.pop_front();
        if (m_tdata_i[COEF_W-1:0] !== want.value)
          report_mismatch("value", m_tdata_i[COEF_W-1:0], want.value);
        if (m_tdata_i[2*COEF_W-1:COEF_W] !== want.slope)
          report_mismatch("slope", m_tdata_i[2*COEF_W-1:COEF_W], want.slope);
        if (m_tuser_i[0] !== want.ovf)
          report_mismatch("overflow", COEF_W'(m_tuser_i[0]), COEF_W'(want.ovf));
        if (want.ovf) saturated_seen_o++;
      end
      results_seen_o++;
    end
    if (s_tvalid_i && s_tready_i) begin
      op  = op_e'(s_tuser_i[0]);
      idx = s_tdata_i[IN_IDX_LSB +: INDEX_W];
      if (op == OP_LOAD) begin
        load_beats_o++;
        if (int'(idx) < MaxTerms) begin
          coef_mem[idx] = s_tdata_i[IN_COEF_LSB +: COEF_W];
        end else begin
          dropped_loads_o++;
        end
      end else begin
        eval_beats_o++;
        owed_results.push_back(predict_eval(s_tdata_i[IN_POINT_LSB +: POINT_W],
                                            s_tdata_i[IN_CNT_LSB +: COUNT_W]));
      end
    end
    owed_count_o = owed_results.size();
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// stimulus for the polynomial value and slope block: fills the coefficient
// memory, runs directed corner evaluations and then a long random mix of
// loads and evaluations with bursty input and a stalling receiver
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pvd_pkg::*;

  localparam int MAX_TERMS      = MAX_TERMS_DEF;
  localparam int RANDOM_ITEMS   = 1200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 48;

  localparam logic [COEF_W-1:0]  COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0]  COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic [COEF_W-1:0]  COEF_ONE = 64'h0001_0000_0000_0000;
  localparam logic [POINT_W-1:0] X_MAX    = {1'b0, {(POINT_W-1){1'b1}}};
  localparam logic [POINT_W-1:0] X_MIN    = {1'b1, {(POINT_W-1){1'b0}}};
  localparam logic [POINT_W-1:0] X_ONE    = 32'h0010_0000;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [0:0]             s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [0:0]             m_axis_tuser;

  int fail_count, owed_count, load_beats, dropped_loads, eval_beats;
  int results_seen, saturated_seen;
  int burst_left;
  int idle_cycles;

  poly_value_and_derivative #(
    .MaxTerms(MAX_TERMS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  poly_eval_checker #(
    .MaxTerms(MAX_TERMS)
  ) i_checker (
    .clk_i           (clk_i),
    .s_tvalid_i      (s_axis_tvalid),
    .s_tready_i      (s_axis_tready),
    .s_tdata_i       (s_axis_tdata),
    .s_tuser_i       (s_axis_tuser),
    .m_tvalid_i      (m_axis_tvalid),
    .m_tready_i      (m_axis_tready),
    .m_tdata_i       (m_axis_tdata),
    .m_tuser_i       (m_axis_tuser),
    .fail_count_o    (fail_count),
    .owed_count_o    (owed_count),
    .load_beats_o    (load_beats),
    .dropped_loads_o (dropped_loads),
    .eval_beats_o    (eval_beats),
    .results_seen_o  (results_seen),
    .saturated_seen_o(saturated_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // receiver: switches between always ready, light and heavy stalling
  always @(negedge clk_i) begin
    int rx_mode;
    int rx_left;
    if (rx_left <= 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= ($urandom_range(0, 7) == 0);
      default: m_axis_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("watchdog: no beat for %0d cycles, %0d results still owed",
             WATCHDOG_LIMIT, owed_count);
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [COEF_W-1:0] rand_coef();
    logic [COEF_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: return v;
      1: begin
        case ($urandom_range(0, 4))
          0: return COEF_MAX;
          1: return COEF_MIN;
          2: return '0;
          3: return COEF_ONE;
          default: return -COEF_ONE;
        endcase
      end
      default: return $signed(v) >>> $urandom_range(8, 60);
    endcase
  endfunction

  function automatic logic [POINT_W-1:0] rand_point();
    logic [POINT_W-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 4))
      0: return v;
      1: begin
        case ($urandom_range(0, 4))
          0: return X_MAX;
          1: return X_MIN;
          2: return '0;
          3: return X_ONE;
          default: return -X_ONE;
        endcase
      end
      default: return $signed(v) >>> $urandom_range(6, 28);
    endcase
  endfunction

  // one input beat, called and returning at a falling edge
  task automatic send_beat(input op_e op, input logic [INDEX_W-1:0] idx,
                           input logic [COEF_W-1:0] coef, input logic [POINT_W-1:0] x,
                           input logic [COUNT_W-1:0] cnt);
    logic [IN_TDATA_W-1:0] beat;
    int                    gap;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 32);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    beat = '0;
    beat[IN_IDX_LSB +: INDEX_W]   = idx;
    beat[IN_COEF_LSB +: COEF_W]   = coef;
    beat[IN_POINT_LSB +: POINT_W] = x;
    beat[IN_CNT_LSB +: COUNT_W]   = cnt;
    s_axis_tdata  <= beat;
    s_axis_tuser  <= op;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic load_coef(input int idx, input logic [COEF_W-1:0] coef);
    send_beat(OP_LOAD, INDEX_W'(idx), coef, $urandom, 3'($urandom_range(0, 7)));
  endtask

  task automatic evaluate(input logic [POINT_W-1:0] x, input int cnt);
    send_beat(OP_EVAL, 3'($urandom_range(0, 7)), {$urandom, $urandom}, x, COUNT_W'(cnt));
  endtask

  initial begin
    int useful;
    int pick;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_LOAD;
    m_axis_tready = 1'b0;
    burst_left    = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: fill memory with extremes, then corner evaluations
    load_coef(0, COEF_MAX);
    load_coef(1, COEF_MIN);
    load_coef(2, COEF_ONE);
    load_coef(3, -COEF_ONE);
    load_coef(4, 64'h0000_8000_0000_0000);
    load_coef(5, '1);
    load_coef(6, {$urandom, $urandom});
    load_coef(7, {$urandom, $urandom});
    evaluate('0, 0);
    evaluate(X_MAX, 1);
    evaluate(X_MIN, 2);
    evaluate(X_ONE, 7);
    evaluate(X_MIN, 6);
    evaluate(X_MAX, 6);
    evaluate('1, 3);
    evaluate('0, 4);
    evaluate(-X_ONE, 5);
    for (int i = 0; i < MAX_TERMS; i++) load_coef(i, $signed({$urandom, $urandom}) >>> 12);
    evaluate(X_ONE, 6);
    evaluate(-X_ONE, 6);

    useful = 0;
    while (useful < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        load_coef($urandom_range(MAX_TERMS, 7), {$urandom, $urandom});
      end else if (pick < 52) begin
        load_coef($urandom_range(0, MAX_TERMS - 1), rand_coef());
        useful++;
      end else begin
        evaluate(rand_point(), ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7)
                                                           : $urandom_range(3, 6));
        useful++;
      end
    end
    s_axis_tvalid <= 1'b0;

    while (owed_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d loads (%0d to out-of-range entries) and %0d evaluations",
             load_beats, dropped_loads, eval_beats);
    $display("%0d results compared, %0d of them saturated", results_seen, saturated_seen);
    if (fail_count == 0 && owed_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== poly_value_and_derivative.f =====
sv/pvd_pkg.sv
sv/pvd_coef_store.sv
sv/pvd_mac.sv
sv/poly_value_and_derivative.sv
tb/poly_eval_checker.sv
tb/tb.sv
